@@ sv/dpdc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Dual PID drive controller package
// Shared widths, constants, register codes and structures of the controller.
// ----------------------------------------------------------------------------
package dpdc_pkg;

   // Field widths.
   localparam int GAIN_W      = 20;
   localparam int POS_W       = 24;
   localparam int HEAD_W      = 13;
   localparam int TDIST_W     = 24;
   localparam int THEAD_W     = 14;
   localparam int CSR_DATA_W  = 24;
   localparam int CSR_INDEX_W = 3;
   localparam int DRIVE_W     = 15;

   // Internal widths.
   localparam int ERR_W   = TDIST_W + 1;   // distance error
   localparam int TERR_W  = THEAD_W + 1;   // heading error
   localparam int INTEG_W = 32;            // integrators
   localparam int X_W     = 32;            // operand of one PID term
   localparam int PROD_W  = 53;            // gain times operand
   localparam int FRAC_W  = 20;            // Q4.16 gain times 2^-4 scaling
   localparam int TERM_W  = 32;            // one saturated term

   // Integrator windows and heading wrap points.
   localparam int LATERAL_BOUND = 1600;
   localparam int TURN_BOUND    = 240;
   localparam int HEAD_HALF     = 2880;
   localparam int HEAD_FULL     = 5760;

   // Term scaling: P is x1000 (millivolts), I is x10, D is x100000.
   localparam longint TERM_LIMIT = 64'sd1 << 30;
   localparam longint ROUND_HALF = 64'sd1 << (FRAC_W - 1);
   localparam longint SCALE_P    = 1000;
   localparam longint SCALE_I    = 10;
   localparam longint SCALE_D    = 100000;
   localparam longint THR_P      = ((64'sd1 << 50) / SCALE_P) + 1;
   localparam longint THR_I      = ((64'sd1 << 50) / SCALE_I) + 1;
   localparam longint THR_D      = ((64'sd1 << 50) / SCALE_D) + 1;
   localparam int     DRIVE_LIMIT = 12000;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_LATERAL_KP      = 3'd0,
      CSR_LATERAL_KI      = 3'd1,
      CSR_LATERAL_KD      = 3'd2,
      CSR_TURN_KP         = 3'd3,
      CSR_TURN_KI         = 3'd4,
      CSR_TURN_KD         = 3'd5,
      CSR_TARGET_DISTANCE = 3'd6,
      CSR_TARGET_HEADING  = 3'd7
   } csr_index_type;

   typedef enum logic [1:0] {
      TERM_P = 2'd0,
      TERM_I = 2'd1,
      TERM_D = 2'd2
   } term_kind_type;

   typedef struct packed {
      logic [GAIN_W-1:0] lateral_kp;
      logic [GAIN_W-1:0] lateral_ki;
      logic [GAIN_W-1:0] lateral_kd;
      logic [GAIN_W-1:0] turn_kp;
      logic [GAIN_W-1:0] turn_ki;
      logic [GAIN_W-1:0] turn_kd;
   } gains_type;

   localparam gains_type GAINS_RESET = '{
      lateral_kp: 20'd1180,
      lateral_ki: 20'd852,
      lateral_kd: 20'd118,
      turn_kp:    20'd20972,
      turn_ki:    20'd15729,
      turn_kd:    20'd1507
   };

   // One classified sample as it waits between front and back.
   typedef struct packed {
      logic signed [ERR_W-1:0]  err;
      logic signed [TERR_W-1:0] terr;
      logic                     lat_win;
      logic                     turn_win;
   } item_type;

   typedef struct packed {
      logic signed [DRIVE_W-1:0] left_drive;
      logic signed [DRIVE_W-1:0] right_drive;
   } drive_type;

endpackage
`default_nettype wire

@@ sv/dpdc_fifo.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Dual PID drive controller queue
// Small first-in first-out queue with the head shown while not empty.
// ----------------------------------------------------------------------------
module dpdc_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff + CNT_W'(do_push) - CNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule
`default_nettype wire

@@ sv/dpdc_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Dual PID drive controller front end
// Holds the gain and target registers and turns each sample into a distance
// error, a heading error and the two integrator window flags.
// ----------------------------------------------------------------------------
module dpdc_front (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write,
   input  logic [dpdc_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [dpdc_pkg::CSR_DATA_W-1:0]      csr_wdata,
   input  logic signed [dpdc_pkg::POS_W-1:0]    left_position,
   input  logic signed [dpdc_pkg::POS_W-1:0]    right_position,
   input  logic [dpdc_pkg::HEAD_W-1:0]          heading,
   output dpdc_pkg::gains_type                  gains,
   output dpdc_pkg::item_type                   item
);
   import dpdc_pkg::*;

   gains_type                 gains_ff, gains_in;
   logic signed [TDIST_W-1:0] target_distance_ff, target_distance_in;
   logic signed [THEAD_W-1:0] target_heading_ff, target_heading_in;

   logic signed [POS_W:0]     pos_sum;
   logic signed [POS_W-1:0]   pos_half;
   logic signed [THEAD_W-1:0] adj_heading;
   logic signed [ERR_W-1:0]   err;
   logic signed [TERR_W-1:0]  terr;

   always_comb begin
      gains_in           = gains_ff;
      target_distance_in = target_distance_ff;
      target_heading_in  = target_heading_ff;
      if (csr_write) begin
         unique case (csr_index_type'(csr_index))
            CSR_LATERAL_KP:      gains_in.lateral_kp = csr_wdata[GAIN_W-1:0];
            CSR_LATERAL_KI:      gains_in.lateral_ki = csr_wdata[GAIN_W-1:0];
            CSR_LATERAL_KD:      gains_in.lateral_kd = csr_wdata[GAIN_W-1:0];
            CSR_TURN_KP:         gains_in.turn_kp    = csr_wdata[GAIN_W-1:0];
            CSR_TURN_KI:         gains_in.turn_ki    = csr_wdata[GAIN_W-1:0];
            CSR_TURN_KD:         gains_in.turn_kd    = csr_wdata[GAIN_W-1:0];
            CSR_TARGET_DISTANCE: target_distance_in  = $signed(csr_wdata[TDIST_W-1:0]);
            CSR_TARGET_HEADING:  target_heading_in   = $signed(csr_wdata[THEAD_W-1:0]);
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gains_ff           <= GAINS_RESET;
         target_distance_ff <= '0;
         target_heading_ff  <= '0;
      end else begin
         gains_ff           <= gains_in;
         target_distance_ff <= target_distance_in;
         target_heading_ff  <= target_heading_in;
      end
   end

   // The encoder average is floored, so dropping the low bit of the sum does it.
   always_comb begin
      pos_sum  = {left_position[POS_W-1], left_position}
               + {right_position[POS_W-1], right_position};
      pos_half = pos_sum[POS_W:1];
      err      = {target_distance_ff[TDIST_W-1], target_distance_ff}
               + {pos_half[POS_W-1], pos_half};

      if (heading <= HEAD_W'(HEAD_HALF)) begin
         adj_heading = {1'b0, heading};
      end else begin
         adj_heading = {1'b0, heading} - THEAD_W'(HEAD_FULL);
      end
      terr = {target_heading_ff[THEAD_W-1], target_heading_ff}
           - {adj_heading[THEAD_W-1], adj_heading};
   end

   assign gains         = gains_ff;
   assign item.err      = err;
   assign item.terr     = terr;
   assign item.lat_win  = (err > $signed(ERR_W'(0))) && (err < $signed(ERR_W'(LATERAL_BOUND)));
   assign item.turn_win = (terr > -$signed(TERR_W'(TURN_BOUND)))
                       && (terr < $signed(TERR_W'(TURN_BOUND)));

endmodule
`default_nettype wire

@@ sv/dpdc_term.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Dual PID drive controller term unit
// Three-stage pipeline for one PID term: gain multiply, clamp and scale,
// then round and saturate to plus or minus 2^30.
// ----------------------------------------------------------------------------
module dpdc_term (
   input  logic                               clock,
   input  dpdc_pkg::term_kind_type            kind,
   input  logic [dpdc_pkg::GAIN_W-1:0]        gain,
   input  logic signed [dpdc_pkg::X_W-1:0]    x,
   output logic signed [dpdc_pkg::TERM_W-1:0] term
);
   import dpdc_pkg::*;

   localparam int SHIFT_W = PROD_W - FRAC_W;

   logic signed [PROD_W-1:0]  prod_ff, prod_in;
   logic signed [PROD_W-1:0]  scaled_ff, scaled_in;
   logic signed [PROD_W-1:0]  thr, clamped, rounded;
   logic signed [SHIFT_W-1:0] shifted;
   logic signed [TERM_W-1:0]  term_ff, term_in;

   assign prod_in = $signed({1'b0, gain}) * x;

   always_comb begin
      unique case (kind)
         TERM_P: begin
            thr = PROD_W'(THR_P);
         end
         TERM_I: begin
            thr = PROD_W'(THR_I);
         end
         TERM_D: begin
            thr = PROD_W'(THR_D);
         end
         default: begin
            thr = PROD_W'(THR_P);
         end
      endcase

      // Clamping at the threshold still lands on the saturated term below,
      // and it keeps the scaled product inside the word.
      priority if (prod_ff >= thr) begin
         clamped = thr;
      end else if (prod_ff <= -thr) begin
         clamped = -thr;
      end else begin
         clamped = prod_ff;
      end

      // The fixed scale factors are built from shifts and adds:
      // 1000 = 1024 - 16 - 8, 10 = 8 + 2 and
      // 100000 = 65536 + 32768 + 1024 + 512 + 128 + 32.
      unique case (kind)
         TERM_P: begin
            scaled_in = (clamped <<< 10) - (clamped <<< 4) - (clamped <<< 3);
         end
         TERM_I: begin
            scaled_in = (clamped <<< 3) + (clamped <<< 1);
         end
         TERM_D: begin
            scaled_in = (clamped <<< 16) + (clamped <<< 15) + (clamped <<< 10)
                      + (clamped <<< 9) + (clamped <<< 7) + (clamped <<< 5);
         end
         default: begin
            scaled_in = (clamped <<< 10) - (clamped <<< 4) - (clamped <<< 3);
         end
      endcase
   end

   always_comb begin
      rounded = scaled_ff + PROD_W'(ROUND_HALF);
      shifted = rounded[PROD_W-1:FRAC_W];
      priority if (shifted > $signed(SHIFT_W'(TERM_LIMIT))) begin
         term_in = TERM_W'(TERM_LIMIT);
      end else if (shifted < -$signed(SHIFT_W'(TERM_LIMIT))) begin
         term_in = TERM_W'(-TERM_LIMIT);
      end else begin
         term_in = shifted[TERM_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      prod_ff   <= prod_in;
      scaled_ff <= scaled_in;
      term_ff   <= term_in;
   end

   assign term = term_ff;

endmodule
`default_nettype wire

@@ sv/dpdc_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Dual PID drive controller back end
// Keeps the loop state, runs the six PID terms and forms the two drives.
// Items enter only when the result queue has a slot reserved for them, so
// the pipeline itself never stalls.
// ----------------------------------------------------------------------------
module dpdc_back #(
   parameter int OUT_DEPTH = 8
) (
   input  logic                clock,
   input  logic                reset,
   input  dpdc_pkg::gains_type gains,
   input  logic                mid_empty,
   input  dpdc_pkg::item_type  mid_item,
   output logic                mid_pop,
   input  logic                out_pop,
   output logic                out_push,
   output dpdc_pkg::drive_type out_item
);
   import dpdc_pkg::*;

   localparam int USED_W  = $clog2(OUT_DEPTH + 1);
   localparam int STAGES  = 5;
   localparam int SUM_W   = INTEG_W + 1;
   localparam int DDIFF_W = ERR_W + 1;
   localparam int TDIFF_W = TERR_W + 1;
   localparam int LOOP_W  = TERM_W + 1;
   localparam int DSUM_W  = LOOP_W + 1;

   function automatic logic signed [INTEG_W-1:0] sat_integ(input logic signed [SUM_W-1:0] v);
      logic signed [INTEG_W-1:0] r;
      priority if (v[SUM_W-1] && !v[SUM_W-2]) begin
         r = {1'b1, {(INTEG_W-1){1'b0}}};
      end else if (!v[SUM_W-1] && v[SUM_W-2]) begin
         r = {1'b0, {(INTEG_W-1){1'b1}}};
      end else begin
         r = v[INTEG_W-1:0];
      end
      return r;
   endfunction

   function automatic logic signed [DRIVE_W-1:0] sat_drive(input logic signed [DSUM_W-1:0] v);
      logic signed [DRIVE_W-1:0] r;
      priority if (v > $signed(DSUM_W'(DRIVE_LIMIT))) begin
         r = DRIVE_W'(DRIVE_LIMIT);
      end else if (v < -$signed(DSUM_W'(DRIVE_LIMIT))) begin
         r = DRIVE_W'(-DRIVE_LIMIT);
      end else begin
         r = v[DRIVE_W-1:0];
      end
      return r;
   endfunction

   logic [USED_W-1:0]         used_ff, used_in;
   logic                      issue;
   logic [STAGES-1:0]         valid_ff, valid_in;

   logic signed [ERR_W-1:0]   prev_err_ff, prev_err_in;
   logic signed [TERR_W-1:0]  prev_terr_ff, prev_terr_in;
   logic signed [INTEG_W-1:0] dist_int_ff, dist_int_in;
   logic signed [INTEG_W-1:0] head_int_ff, head_int_in;
   logic signed [SUM_W-1:0]   dist_sum, head_sum;

   logic signed [ERR_W-1:0]   s1_err_ff;
   logic signed [TERR_W-1:0]  s1_terr_ff;
   logic signed [INTEG_W-1:0] s1_dint_ff, s1_hint_ff;
   logic signed [DDIFF_W-1:0] s1_derr_ff, s1_derr_in;
   logic signed [TDIFF_W-1:0] s1_tderr_ff, s1_tderr_in;

   logic signed [TERM_W-1:0]  lat_p, lat_i, lat_d, turn_p, turn_i, turn_d;
   logic signed [LOOP_W-1:0]  lat_ff, lat_in, turn_ff, turn_in;

   // A slot in the result queue is reserved at entry and freed on the result
   // transfer.
   assign issue   = !mid_empty && (used_ff < USED_W'(OUT_DEPTH));
   assign mid_pop = issue;
   assign used_in = used_ff + USED_W'(issue) - USED_W'(out_pop);
   assign valid_in = {valid_ff[STAGES-2:0], issue};

   always_comb begin
      dist_sum = $signed({dist_int_ff[INTEG_W-1], dist_int_ff}) + SUM_W'($signed(mid_item.err));
      head_sum = $signed({head_int_ff[INTEG_W-1], head_int_ff}) + SUM_W'($signed(mid_item.terr));
      s1_derr_in  = DDIFF_W'($signed(mid_item.err)) - DDIFF_W'(prev_err_ff);
      s1_tderr_in = TDIFF_W'($signed(mid_item.terr)) - TDIFF_W'(prev_terr_ff);

      prev_err_in  = prev_err_ff;
      prev_terr_in = prev_terr_ff;
      dist_int_in  = dist_int_ff;
      head_int_in  = head_int_ff;
      if (issue) begin
         prev_err_in  = mid_item.err;
         prev_terr_in = mid_item.terr;
         dist_int_in  = mid_item.lat_win ? sat_integ(dist_sum) : '0;
         head_int_in  = mid_item.turn_win ? sat_integ(head_sum) : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff      <= '0;
         valid_ff     <= '0;
         prev_err_ff  <= '0;
         prev_terr_ff <= '0;
         dist_int_ff  <= '0;
         head_int_ff  <= '0;
      end else begin
         used_ff      <= used_in;
         valid_ff     <= valid_in;
         prev_err_ff  <= prev_err_in;
         prev_terr_ff <= prev_terr_in;
         dist_int_ff  <= dist_int_in;
         head_int_ff  <= head_int_in;
      end
   end

   // The terms see the integrals after this sample has been added.
   always_ff @(posedge clock) begin
      s1_err_ff   <= mid_item.err;
      s1_terr_ff  <= mid_item.terr;
      s1_dint_ff  <= dist_int_in;
      s1_hint_ff  <= head_int_in;
      s1_derr_ff  <= s1_derr_in;
      s1_tderr_ff <= s1_tderr_in;
   end

   dpdc_term u_lat_p (
      .clock (clock), .kind (TERM_P), .gain (gains.lateral_kp),
      .x (X_W'(s1_err_ff)), .term (lat_p)
   );
   dpdc_term u_lat_i (
      .clock (clock), .kind (TERM_I), .gain (gains.lateral_ki),
      .x (X_W'(s1_dint_ff)), .term (lat_i)
   );
   dpdc_term u_lat_d (
      .clock (clock), .kind (TERM_D), .gain (gains.lateral_kd),
      .x (X_W'(s1_derr_ff)), .term (lat_d)
   );
   dpdc_term u_turn_p (
      .clock (clock), .kind (TERM_P), .gain (gains.turn_kp),
      .x (X_W'(s1_terr_ff)), .term (turn_p)
   );
   dpdc_term u_turn_i (
      .clock (clock), .kind (TERM_I), .gain (gains.turn_ki),
      .x (X_W'(s1_hint_ff)), .term (turn_i)
   );
   dpdc_term u_turn_d (
      .clock (clock), .kind (TERM_D), .gain (gains.turn_kd),
      .x (X_W'(s1_tderr_ff)), .term (turn_d)
   );

   assign lat_in  = LOOP_W'(lat_p) + LOOP_W'(lat_i) + LOOP_W'(lat_d);
   assign turn_in = LOOP_W'(turn_p) + LOOP_W'(turn_i) + LOOP_W'(turn_d);

   always_ff @(posedge clock) begin
      lat_ff  <= lat_in;
      turn_ff <= turn_in;
   end

   assign out_push             = valid_ff[STAGES-1];
   assign out_item.left_drive  = sat_drive(DSUM_W'(lat_ff) + DSUM_W'(turn_ff));
   assign out_item.right_drive = sat_drive(DSUM_W'(lat_ff) - DSUM_W'(turn_ff));

   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      used_ff <= USED_W'(OUT_DEPTH))
      else $error("result slots overbooked");

   a_no_orphans: assert property (@(posedge clock) disable iff (reset)
      (used_ff == '0) |-> (valid_ff == '0))
      else $error("item in flight without a reserved result slot");

   a_latency: assert property (@(posedge clock) disable iff (reset)
      issue |-> ##5 out_push)
      else $error("issued item did not reach the result queue on time");

   a_dist_int_sign: assert property (@(posedge clock) disable iff (reset)
      !dist_int_ff[INTEG_W-1])
      else $error("distance integral went negative");

endmodule
`default_nettype wire

@@ sv/dual_pid_drive_controller.sv @@
// A result reaches the result ports after its request transfer by way of the
// queue write, integrator update, gain multiply, scale, round and loop sum.
// Throughput: one transfer per cycle sustained, set by the fully pipelined
// back end, which takes one item per cycle while result slots are free.
// Reset is synchronous: it empties both queues, clears integrals and previous
// errors, and loads the default gains and zero targets.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Dual PID drive controller
// Distance and heading PID loops for a differential-drive base, giving left
// and right drive commands in millivolts.
// ----------------------------------------------------------------------------
module dual_pid_drive_controller #(
   parameter int MID_DEPTH = 4,
   parameter int OUT_DEPTH = 8
) (
   input  logic                                    clock,
   input  logic                                    reset,

   // Request channel: a transfer happens when push is high and full is low.
   input  logic                                    push,
   output logic                                    full,
   input  logic signed [dpdc_pkg::POS_W-1:0]       req_left_position,
   input  logic signed [dpdc_pkg::POS_W-1:0]       req_right_position,
   input  logic [dpdc_pkg::HEAD_W-1:0]             req_heading,

   // Response channel: a transfer happens when pop is high and empty is low.
   output logic                                    empty,
   input  logic                                    pop,
   output logic signed [dpdc_pkg::DRIVE_W-1:0]     rsp_left_drive,
   output logic signed [dpdc_pkg::DRIVE_W-1:0]     rsp_right_drive,

   // Register write port.
   input  logic                                    csr_write,
   input  logic [dpdc_pkg::CSR_INDEX_W-1:0]        csr_index,
   input  logic [dpdc_pkg::CSR_DATA_W-1:0]         csr_wdata
);
   import dpdc_pkg::*;

   gains_type gains;
   item_type  front_item;
   item_type  mid_item;
   logic      mid_empty;
   logic      mid_pop;
   logic      req_xfer;
   logic      rsp_xfer;
   logic      out_push;
   logic      out_full;
   drive_type out_item;
   drive_type rsp_item;

   assign req_xfer = push && !full;
   assign rsp_xfer = pop && !empty;

   // The front end computes the two errors and the integrator window flags
   // straight from the request, so the sample is classified as it is taken.
   dpdc_front u_front (
      .clock          (clock),
      .reset          (reset),
      .csr_write      (csr_write),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .left_position  (req_left_position),
      .right_position (req_right_position),
      .heading        (req_heading),
      .gains          (gains),
      .item           (front_item)
   );

   // The short queue between front and back lets the request side keep
   // accepting while the back end waits for a free result slot.
   dpdc_fifo #(
      .WIDTH ($bits(item_type)),
      .DEPTH (MID_DEPTH)
   ) u_mid_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_xfer),
      .push_data (front_item),
      .full      (full),
      .pop       (mid_pop),
      .pop_data  (mid_item),
      .empty     (mid_empty)
   );

   // The back end owns all loop state. It reserves a result slot for each item
   // it takes, so the result queue can never overflow and the pipeline runs
   // without stalls.
   dpdc_back #(
      .OUT_DEPTH (OUT_DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .gains     (gains),
      .mid_empty (mid_empty),
      .mid_item  (mid_item),
      .mid_pop   (mid_pop),
      .out_pop   (rsp_xfer),
      .out_push  (out_push),
      .out_item  (out_item)
   );

   // Finished results wait here until the consumer takes them. The full flag
   // is never reached with a push pending because of the slot reservation.
   dpdc_fifo #(
      .WIDTH ($bits(drive_type)),
      .DEPTH (OUT_DEPTH)
   ) u_out_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (out_push),
      .push_data (out_item),
      .full      (out_full),
      .pop       (pop),
      .pop_data  (rsp_item),
      .empty     (empty)
   );

   assign rsp_left_drive  = rsp_item.left_drive;
   assign rsp_right_drive = rsp_item.right_drive;

   a_out_no_overflow: assert property (@(posedge clock) disable iff (reset)
      out_push |-> !out_full)
      else $error("result queue written while full");

   a_mid_drains: assert property (@(posedge clock) disable iff (reset)
      (!mid_empty && empty) |-> mid_pop)
      else $error("back end idle with work queued and no results waiting");

   a_rsp_needs_req: assert property (@(posedge clock) disable iff (reset)
      (mid_empty && $past(mid_empty) && empty && $past(empty) && !$past(req_xfer))
         |=> (empty || $past(out_push)))
      else $error("result appeared without a request");

endmodule
`default_nettype wire

@@ dv/drive_check.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Drive command checker
// Watches the request, response and register ports of the dual PID drive
// controller, predicts each drive command and compares it on transfer.
// ----------------------------------------------------------------------------
module drive_check (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    push,
   input  logic                                    full,
   input  logic signed [dpdc_pkg::POS_W-1:0]       req_left_position,
   input  logic signed [dpdc_pkg::POS_W-1:0]       req_right_position,
   input  logic [dpdc_pkg::HEAD_W-1:0]             req_heading,
   input  logic                                    empty,
   input  logic                                    pop,
   input  logic signed [dpdc_pkg::DRIVE_W-1:0]     rsp_left_drive,
   input  logic signed [dpdc_pkg::DRIVE_W-1:0]     rsp_right_drive,
   input  logic                                    csr_write,
   input  logic [dpdc_pkg::CSR_INDEX_W-1:0]        csr_index,
   input  logic [dpdc_pkg::CSR_DATA_W-1:0]         csr_wdata,
   output int                                      failures,
   output int                                      pending
);
   import dpdc_pkg::*;

   localparam longint INTEG_MAX = (64'sd1 <<< (INTEG_W - 1)) - 1;
   localparam longint INTEG_MIN = -(64'sd1 <<< (INTEG_W - 1));

   gains_type                 gains;
   logic signed [TDIST_W-1:0] target_distance;
   logic signed [THEAD_W-1:0] target_heading;
   longint                    last_distance_error;
   longint                    distance_sum;
   longint                    last_heading_error;
   longint                    heading_sum;
   drive_type                 expected_drives[$];
   int                        mismatch_count = 0;
   int                        outstanding = 0;

   assign failures = mismatch_count;
   assign pending  = outstanding;

   // Gain times operand, scaled to millivolts, rounded half up, clipped.
   function automatic longint scaled_term(longint gain, longint operand, longint scale);
      longint product;
      longint threshold;
      product   = gain * operand;
      threshold = ((TERM_LIMIT << FRAC_W) / scale) + 1;
      if (product >= threshold) begin
         return TERM_LIMIT;
      end
      if (product <= -threshold) begin
         return -TERM_LIMIT;
      end
      return (product * scale + ROUND_HALF) >>> FRAC_W;
   endfunction

   function automatic longint bounded_sum(longint acc, longint step);
      longint total;
      total = acc + step;
      if (total > INTEG_MAX) begin
         total = INTEG_MAX;
      end else if (total < INTEG_MIN) begin
         total = INTEG_MIN;
      end
      return total;
   endfunction

   function automatic logic signed [DRIVE_W-1:0] clamp_drive(longint level);
      if (level > DRIVE_LIMIT) begin
         level = DRIVE_LIMIT;
      end else if (level < -DRIVE_LIMIT) begin
         level = -DRIVE_LIMIT;
      end
      return level[DRIVE_W-1:0];
   endfunction

   // Runs both loops for one sample and returns the drive pair it yields.
   function automatic drive_type advance_loops(logic signed [POS_W-1:0] left,
                                               logic signed [POS_W-1:0] right,
                                               logic [HEAD_W-1:0] heading);
      longint    encoder_sum;
      longint    distance_error;
      longint    heading_now;
      longint    heading_error;
      longint    lateral;
      longint    turn;
      drive_type drives;
      encoder_sum    = longint'(left) + longint'(right);
      distance_error = longint'(target_distance) + (encoder_sum >>> 1);
      heading_now    = longint'(heading);
      if (heading_now > HEAD_HALF) begin
         heading_now = heading_now - HEAD_FULL;
      end
      heading_error = longint'(target_heading) - heading_now;

      if (distance_error > 0 && distance_error < LATERAL_BOUND) begin
         distance_sum = bounded_sum(distance_sum, distance_error);
      end else begin
         distance_sum = 0;
      end
      if (heading_error > -TURN_BOUND && heading_error < TURN_BOUND) begin
         heading_sum = bounded_sum(heading_sum, heading_error);
      end else begin
         heading_sum = 0;
      end

      lateral = scaled_term(gains.lateral_kp, distance_error, SCALE_P)
              + scaled_term(gains.lateral_ki, distance_sum, SCALE_I)
              + scaled_term(gains.lateral_kd, distance_error - last_distance_error, SCALE_D);
      turn    = scaled_term(gains.turn_kp, heading_error, SCALE_P)
              + scaled_term(gains.turn_ki, heading_sum, SCALE_I)
              + scaled_term(gains.turn_kd, heading_error - last_heading_error, SCALE_D);

      last_distance_error = distance_error;
      last_heading_error  = heading_error;
      drives.left_drive   = clamp_drive(lateral + turn);
      drives.right_drive  = clamp_drive(lateral - turn);
      return drives;
   endfunction

   always @(posedge clock) begin
      drive_type want;
      if (reset) begin
         gains               = GAINS_RESET;
         target_distance     = '0;
         target_heading      = '0;
         last_distance_error = 0;
         distance_sum        = 0;
         last_heading_error  = 0;
         heading_sum         = 0;
         expected_drives.delete();
      end else begin
         if (csr_write) begin
            case (csr_index_type'(csr_index))
               CSR_LATERAL_KP:      gains.lateral_kp = csr_wdata[GAIN_W-1:0];
               CSR_LATERAL_KI:      gains.lateral_ki = csr_wdata[GAIN_W-1:0];
               CSR_LATERAL_KD:      gains.lateral_kd = csr_wdata[GAIN_W-1:0];
               CSR_TURN_KP:         gains.turn_kp    = csr_wdata[GAIN_W-1:0];
               CSR_TURN_KI:         gains.turn_ki    = csr_wdata[GAIN_W-1:0];
               CSR_TURN_KD:         gains.turn_kd    = csr_wdata[GAIN_W-1:0];
               CSR_TARGET_DISTANCE: target_distance  = csr_wdata[TDIST_W-1:0];
               CSR_TARGET_HEADING:  target_heading   = csr_wdata[THEAD_W-1:0];
               default: ;
            endcase
         end

         // Results are checked before new samples are queued, so a result
         // can never be matched against a sample taken at the same edge.
         if (pop && !empty) begin
            if (expected_drives.size() == 0) begin
               $error("drive command transfer with no expected command: left %0d right %0d",
                      rsp_left_drive, rsp_right_drive);
               mismatch_count++;
            end else begin
               want = expected_drives.pop_front();
               if (rsp_left_drive !== want.left_drive) begin
                  $error("left_drive: expected %0d, actual %0d",
                         $signed(want.left_drive), rsp_left_drive);
                  mismatch_count++;
               end
               if (rsp_right_drive !== want.right_drive) begin
                  $error("right_drive: expected %0d, actual %0d",
                         $signed(want.right_drive), rsp_right_drive);
                  mismatch_count++;
               end
            end
         end

         if (push && !full) begin
            expected_drives.push_back(advance_loops(req_left_position, req_right_position,
                                                    req_heading));
         end
      end
      outstanding = expected_drives.size();
   end

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dual PID drive controller testbench
// Drives encoder and heading samples through the controller under several
// gain and target settings, with random stalls on both channels, and lets a
// checker compare every drive command with its own prediction.
// ----------------------------------------------------------------------------
module tb;
   import dpdc_pkg::*;

   localparam int     CLOCK_HALF      = 6;
   localparam int     RESET_CYCLES    = 6;
   localparam int     CYCLE_LIMIT     = 400000;
   localparam int     MAX_GAP         = 17;
   localparam int     HOLD_OFF_AT     = 500;
   localparam int     HOLD_OFF_CYCLES = 500;
   localparam int     SETTLE_CYCLES   = 20;
   localparam int     FIRST_RANDOM    = 250;
   localparam int     EXTREME_ITEMS   = 60;
   localparam int     RANDOM_PHASES   = 7;
   localparam int     PHASE_ITEMS     = 140;
   localparam longint POS_HIGH        = (64'sd1 <<< (POS_W - 1)) - 1;
   localparam longint POS_LOW         = -(64'sd1 <<< (POS_W - 1));

   localparam logic signed [POS_W-1:0] POS_MAX = 24'sh7FFFFF;
   localparam logic signed [POS_W-1:0] POS_MIN = 24'sh800000;

   typedef enum {
      SETTING_ZERO,
      SETTING_HIGH,
      SETTING_LOW,
      SETTING_RANDOM
   } setting_kind_type;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        push = 1'b0;
   logic                        full;
   logic signed [POS_W-1:0]     req_left_position = '0;
   logic signed [POS_W-1:0]     req_right_position = '0;
   logic [HEAD_W-1:0]           req_heading = '0;
   logic                        empty;
   logic                        pop = 1'b0;
   logic signed [DRIVE_W-1:0]   rsp_left_drive;
   logic signed [DRIVE_W-1:0]   rsp_right_drive;
   logic                        csr_write = 1'b0;
   logic [CSR_INDEX_W-1:0]      csr_index = '0;
   logic [CSR_DATA_W-1:0]       csr_wdata = '0;

   int                          failures;
   int                          pending;
   int                          cycle_count = 0;
   int                          drives_taken = 0;
   bit                          send_calm = 1'b0;
   bit                          take_calm = 1'b0;
   int                          run_left = 0;
   bit                          run_tracking = 1'b0;

   // Copies of the targets last written, used only to steer the stimulus
   // toward the integrator windows.
   logic signed [TDIST_W-1:0]   goal_distance = '0;
   logic signed [THEAD_W-1:0]   goal_heading = '0;

   always begin
      #CLOCK_HALF clock = 1'b1;
      #CLOCK_HALF clock = 1'b0;
   end

   dual_pid_drive_controller uut (
      .clock              (clock),
      .reset              (reset),
      .push               (push),
      .full               (full),
      .req_left_position  (req_left_position),
      .req_right_position (req_right_position),
      .req_heading        (req_heading),
      .empty              (empty),
      .pop                (pop),
      .rsp_left_drive     (rsp_left_drive),
      .rsp_right_drive    (rsp_right_drive),
      .csr_write          (csr_write),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   drive_check drive_check_i (
      .clock              (clock),
      .reset              (reset),
      .push               (push),
      .full               (full),
      .req_left_position  (req_left_position),
      .req_right_position (req_right_position),
      .req_heading        (req_heading),
      .empty              (empty),
      .pop                (pop),
      .rsp_left_drive     (rsp_left_drive),
      .rsp_right_drive    (rsp_right_drive),
      .csr_write          (csr_write),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .failures           (failures),
      .pending            (pending)
   );

   // A hung handshake must not stall the run forever.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // Offers one sample and returns right after the edge that takes it.
   // Push stays high past that edge; the next call either lowers it for a
   // gap or replaces the data at the following falling edge.
   task automatic offer_sample(input logic signed [POS_W-1:0] left,
                               input logic signed [POS_W-1:0] right,
                               input logic [HEAD_W-1:0] heading);
      int gap;
      gap = send_calm ? 0 : $urandom_range(0, MAX_GAP);
      repeat (gap) begin
         @(negedge clock);
         push <= 1'b0;
      end
      @(negedge clock);
      push               <= 1'b1;
      req_left_position  <= left;
      req_right_position <= right;
      req_heading        <= heading;
      @(posedge clock);
      while (full) @(posedge clock);
   endtask

   // Random samples come in runs. A tracking run keeps both errors close to
   // the integrator windows so that the integrals build up over many items;
   // a noise run throws in arbitrary encoder and heading values that reset
   // the integrals and exercise the saturation paths.
   task automatic random_sample();
      longint                  distance_error;
      longint                  heading_error;
      longint                  encoder_sum;
      longint                  left;
      longint                  right;
      longint                  wrapped;
      logic signed [POS_W-1:0] left_word;
      logic signed [POS_W-1:0] right_word;
      logic [HEAD_W-1:0]       heading;
      if (run_left == 0) begin
         run_tracking = ($urandom_range(0, 3) != 0);
         run_left     = run_tracking ? $urandom_range(5, 40) : $urandom_range(1, 5);
      end
      run_left--;
      if (run_tracking) begin
         if ($urandom_range(0, 4) == 0) begin
            distance_error = longint'($urandom_range(0, 4000)) - 2000;
         end else begin
            distance_error = longint'($urandom_range(1, LATERAL_BOUND - 1));
         end
         heading_error = longint'($urandom_range(0, 2 * TURN_BOUND + 100)) - (TURN_BOUND + 50);
         encoder_sum   = 2 * (distance_error - longint'(goal_distance))
                       + longint'($urandom_range(0, 1));
         left          = (encoder_sum >>> 1) + longint'($urandom_range(0, 200000)) - 100000;
         right         = encoder_sum - left;
         if (left > POS_HIGH || left < POS_LOW || right > POS_HIGH || right < POS_LOW) begin
            // Targets near the ends of the range leave no room for such a
            // pair, so take arbitrary encoders instead.
            left  = longint'(POS_W'($urandom));
            right = longint'(POS_W'($urandom));
         end
         wrapped = longint'(goal_heading) - heading_error;
         heading = HEAD_W'(((wrapped % HEAD_FULL) + HEAD_FULL) % HEAD_FULL);
         if ($urandom_range(0, 19) == 0) begin
            heading = HEAD_W'($urandom_range(HEAD_FULL, (1 << HEAD_W) - 1));
         end
         left_word  = left[POS_W-1:0];
         right_word = right[POS_W-1:0];
      end else begin
         if ($urandom_range(0, 1) == 0) begin
            left_word  = POS_W'($urandom);
            right_word = POS_W'($urandom);
         end else begin
            left_word  = POS_W'($urandom_range(0, 10000) - 5000);
            right_word = POS_W'($urandom_range(0, 10000) - 5000);
         end
         heading = HEAD_W'($urandom_range(0, (1 << HEAD_W) - 1));
      end
      offer_sample(left_word, right_word, heading);
   endtask

   task automatic write_register(input csr_index_type index,
                                 input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(negedge clock);
      csr_write <= 1'b0;
      if (index == CSR_TARGET_DISTANCE) begin
         goal_distance = value[TDIST_W-1:0];
      end else if (index == CSR_TARGET_HEADING) begin
         goal_heading = value[THEAD_W-1:0];
      end
   endtask

   // Loads all eight registers. Upper data bits beyond a register's width
   // carry junk in several settings, since the block must drop them.
   task automatic apply_setting(input setting_kind_type kind);
      logic [CSR_DATA_W-1:0] gain_word;
      logic [CSR_DATA_W-1:0] distance_word;
      logic [CSR_DATA_W-1:0] heading_word;
      for (int i = 0; i <= int'(CSR_TURN_KD); i++) begin
         case (kind)
            SETTING_ZERO: gain_word = '0;
            SETTING_HIGH: gain_word = 24'h0FFFFF;
            SETTING_LOW:  gain_word = 24'hFFFFFF;
            default:      gain_word = {4'($urandom), 20'($urandom) >> $urandom_range(0, 19)};
         endcase
         write_register(csr_index_type'(i), gain_word);
      end
      case (kind)
         SETTING_ZERO: begin
            distance_word = '0;
            heading_word  = '0;
         end
         SETTING_HIGH: begin
            distance_word = 24'h7FFFFF;
            heading_word  = 24'h001FFF;
         end
         SETTING_LOW: begin
            distance_word = 24'h800000;
            heading_word  = 24'hFFE000;
         end
         default: begin
            case ($urandom_range(0, 3))
               0:       distance_word = '0;
               1:       distance_word = 24'($urandom);
               default: distance_word = 24'($urandom_range(0, 60000) - 30000);
            endcase
            if ($urandom_range(0, 3) == 0) begin
               heading_word = 24'($urandom);
            end else begin
               heading_word = {10'($urandom), 14'($urandom_range(0, 2 * HEAD_FULL) - HEAD_FULL)};
            end
         end
      endcase
      write_register(CSR_TARGET_DISTANCE, distance_word);
      write_register(CSR_TARGET_HEADING, heading_word);
   endtask

   // Lowers push and waits until every expected command has been taken, so
   // that the block is idle before the registers change.
   task automatic wait_idle();
      @(negedge clock);
      push <= 1'b0;
      while (pending != 0) @(negedge clock);
   endtask

   task automatic run_phase(input setting_kind_type kind, input int items);
      wait_idle();
      apply_setting(kind);
      send_calm = ($urandom_range(0, 3) == 0);
      repeat (items) random_sample();
   endtask

   // Result side: a random wait before each transfer, with calm stretches,
   // and one long hold-off in the middle of the run so that the block fills
   // up and pushes back on the request side.
   initial begin
      int gap;
      wait (!reset);
      forever begin
         if (drives_taken == HOLD_OFF_AT) begin
            @(negedge clock);
            pop <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
         end
         if (drives_taken % 40 == 0) begin
            take_calm = ($urandom_range(0, 3) == 0);
         end
         gap = take_calm ? 0 : $urandom_range(0, MAX_GAP);
         repeat (gap) begin
            @(negedge clock);
            pop <= 1'b0;
         end
         @(negedge clock);
         pop <= 1'b1;
         @(posedge clock);
         while (empty) @(posedge clock);
         drives_taken++;
      end
   end

   // Request side and verdict.
   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed samples under the reset gains and zero targets.
      offer_sample('0, '0, '0);
      offer_sample(POS_MAX, POS_MAX, 13'd0);
      offer_sample(POS_MIN, POS_MIN, 13'd5759);
      // Odd encoder sums: the half average floors toward minus infinity.
      offer_sample(POS_MAX, POS_MIN, 13'd2880);
      offer_sample(24'sd1, 24'sd0, 13'd2881);
      offer_sample(-24'sd3, 24'sd0, 13'd5760);
      // A heading beyond a full turn still takes the wrapped path.
      offer_sample('0, '0, 13'h1FFF);
      // Small positive distance errors and small heading errors let both
      // integrals grow across consecutive samples.
      offer_sample(24'sd100, 24'sd100, 13'd10);
      offer_sample(24'sd100, 24'sd102, 13'd10);
      offer_sample(24'sd150, 24'sd150, 13'd5750);
      repeat (4) offer_sample(24'sd200, 24'sd200, 13'd3);
      // Edges of the integrator windows.
      offer_sample(24'sd1599, 24'sd1599, 13'd0);
      offer_sample(24'sd1600, 24'sd1600, 13'd0);
      offer_sample(-24'sd500, -24'sd500, 13'd239);
      offer_sample(24'sd1, 24'sd1, 13'd5521);
      offer_sample(-24'sd1600, -24'sd1600, 13'd240);
      offer_sample(24'sh555555, 24'sh2AAAAA, 13'h0AAA);
      offer_sample(24'sh2AAAAA, 24'sh555555, 13'h1555);
      repeat (FIRST_RANDOM) random_sample();

      run_phase(SETTING_HIGH, EXTREME_ITEMS);
      run_phase(SETTING_LOW, EXTREME_ITEMS);
      run_phase(SETTING_ZERO, EXTREME_ITEMS);
      repeat (RANDOM_PHASES) run_phase(SETTING_RANDOM, PHASE_ITEMS);

      wait_idle();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (failures == 0 && pending == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
